// ===== design/kscs_pkg.sv =====
// Shared types and constants for the keyword substitution cipher.
package kscs_pkg;

  localparam logic [7:0] FIRST_LETTER = 8'h61;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_TEXT   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PASS      = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_KEY,
    OP_FINISH,
    OP_TEXT
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_FILL
  } bk_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       letter;
  } entry_t;

endpackage

// ===== design/kscs_front.sv =====
// Front end: accepts items, decodes the command and drops keyword characters that are not letters.
module kscs_front #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic             req_valid,
  output logic             req_ready,
  input  kscs_pkg::req_t   req_item,
  output logic             push_valid,
  input  logic             push_ready,
  output kscs_pkg::entry_t push_entry
);

  logic [7:0] ch_off;
  logic       letter;
  logic       keep;

  assign ch_off = req_item.ch - kscs_pkg::FIRST_LETTER;
  assign letter = (req_item.ch >= kscs_pkg::FIRST_LETTER) &&
                  ({1'b0, ch_off} < 9'(ALPHABET_SIZE));

  always_comb begin
    push_entry.ch     = req_item.ch;
    push_entry.letter = letter;
    keep              = 1'b1;
    case (req_item.cmd)
      kscs_pkg::CMD_CLEAR:  push_entry.op = kscs_pkg::OP_CLEAR;
      kscs_pkg::CMD_KEY: begin
        push_entry.op = kscs_pkg::OP_KEY;
        keep          = letter;
      end
      kscs_pkg::CMD_FINISH: push_entry.op = kscs_pkg::OP_FINISH;
      default:              push_entry.op = kscs_pkg::OP_TEXT;
    endcase
  end

  assign push_valid = req_valid && keep;
  assign req_ready  = push_ready;

endmodule

// ===== design/kscs_fifo.sv =====
// Short queue of decoded items between the front end and the back end.
module kscs_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  kscs_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output kscs_pkg::entry_t pop_entry
);

  localparam int PTR_W = $clog2(kscs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(kscs_pkg::QUEUE_DEPTH + 1);

  kscs_pkg::entry_t slots [kscs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(kscs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== design/kscs_back.sv =====
// Back end: key tables, key building, alphabet fill walk and text substitution.
module kscs_back #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  kscs_pkg::entry_t pop_entry,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output kscs_pkg::rsp_t   rsp_item
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ALPHABET_SIZE - 1);

  logic [IDX_W-1:0]         fwd [ALPHABET_SIZE];
  logic [IDX_W-1:0]         inv [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] used;
  logic [CNT_W-1:0]         fill;
  logic                     key_ready;
  logic                     key_ready_next;
  logic                     decrypt_mode;
  logic [IDX_W-1:0]         walk;
  logic [IDX_W-1:0]         walk_next;
  kscs_pkg::bk_state_t      state;
  kscs_pkg::bk_state_t      state_next;

  logic [7:0]       ch_off;
  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0] app_idx;
  logic             app_en;
  logic             app_ok;
  logic             clear;
  logic             load_out;
  logic [IDX_W-1:0] mapped;
  kscs_pkg::rsp_t   rsp_next;

  assign ch_off = pop_entry.ch - kscs_pkg::FIRST_LETTER;
  assign ch_idx = ch_off[IDX_W-1:0];

  always_comb begin
    state_next     = state;
    walk_next      = walk;
    key_ready_next = key_ready;
    pop_ready      = 1'b0;
    app_en         = 1'b0;
    app_idx        = ch_idx;
    clear          = 1'b0;
    load_out       = 1'b0;
    case (state)
      kscs_pkg::BK_RUN: begin
        if (pop_valid) begin
          case (pop_entry.op)
            kscs_pkg::OP_CLEAR: begin
              pop_ready      = 1'b1;
              clear          = 1'b1;
              key_ready_next = 1'b0;
            end
            kscs_pkg::OP_KEY: begin
              pop_ready = 1'b1;
              app_en    = !key_ready && pop_entry.letter;
            end
            kscs_pkg::OP_FINISH: begin
              pop_ready = 1'b1;
              if (!key_ready) begin
                state_next = kscs_pkg::BK_FILL;
                walk_next  = '0;
              end
            end
            kscs_pkg::OP_TEXT: begin
              if (!rsp_valid || rsp_ready) begin
                pop_ready = 1'b1;
                load_out  = 1'b1;
              end
            end
            default: pop_ready = 1'b1;
          endcase
        end
      end
      kscs_pkg::BK_FILL: begin
        app_en    = 1'b1;
        app_idx   = walk;
        walk_next = walk + 1'b1;
        if (walk == LAST) begin
          state_next     = kscs_pkg::BK_RUN;
          key_ready_next = 1'b1;
        end
      end
      default: state_next = kscs_pkg::BK_RUN;
    endcase
  end

  assign app_ok = app_en && !used[app_idx] && (fill < CNT_W'(ALPHABET_SIZE));

  assign mapped = decrypt_mode ? inv[ch_idx] : fwd[ch_idx];

  always_comb begin
    if (!key_ready) begin
      rsp_next.out_char = pop_entry.ch;
      rsp_next.status   = kscs_pkg::ST_NOT_READY;
    end else if (!pop_entry.letter) begin
      rsp_next.out_char = pop_entry.ch;
      rsp_next.status   = kscs_pkg::ST_PASS;
    end else begin
      rsp_next.out_char = kscs_pkg::FIRST_LETTER + 8'(mapped);
      rsp_next.status   = kscs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kscs_pkg::BK_RUN;
      walk         <= '0;
      key_ready    <= 1'b0;
      used         <= '0;
      fill         <= '0;
      decrypt_mode <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      walk      <= walk_next;
      key_ready <= key_ready_next;
      if (cfg_we) begin
        decrypt_mode <= cfg_data;
      end
      if (clear) begin
        used <= '0;
        fill <= '0;
      end else if (app_ok) begin
        used[app_idx] <= 1'b1;
        fill          <= fill + 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_ok) begin
      fwd[fill[IDX_W-1:0]] <= app_idx;
      inv[app_idx]         <= fill[IDX_W-1:0];
    end
    if (load_out) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

// ===== design/keyword_substitution_cipher_top.sv =====
// Top level of the keyword substitution cipher.
//
//  Channel | Signals                        | Moves
//  req     | req_valid, req_ready, req_item | one command item: cmd and ch
//  rsp     | rsp_valid, rsp_ready, rsp_item | one result item for each text item
//  cfg     | cfg_we, cfg_data               | decrypt_mode, registered while cfg_we is high
//
// Clear and keyword items pass the back end at one item per cycle, and text items do too
// while results are taken; an item passes through a queue slot, and its result is offered
// from the output register.
// A finish item that completes the key holds the back end while the fill walk steps through
// every letter; the four-entry queue keeps accepting items meanwhile until it is full.
// Reset is synchronous: it empties the queue and clears the key state, with no clearing pass.
// A stalled result holds in the output register; only non-text items keep running meanwhile.
module keyword_substitution_cipher_top #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           req_valid,
  output logic           req_ready,
  input  kscs_pkg::req_t req_item,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output kscs_pkg::rsp_t rsp_item
);

  logic             push_valid;
  logic             push_ready;
  kscs_pkg::entry_t push_entry;
  logic             pop_valid;
  logic             pop_ready;
  kscs_pkg::entry_t pop_entry;

  kscs_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry)
  );

  kscs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry)
  );

  kscs_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item (rsp_item)
  );

endmodule

// ===== design/kscs_checker.sv =====
// Port checker for the keyword substitution cipher and its bind to the top level.
module kscs_checker #(
  parameter int ALPHABET_SIZE = 26
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input kscs_pkg::req_t req_item,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input kscs_pkg::rsp_t rsp_item
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_item))
    else $error("input item changed while waiting");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && req_ready)
    else $error("block not empty after reset");

  a_ok_letter: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status == kscs_pkg::ST_OK |->
      rsp_item.out_char >= kscs_pkg::FIRST_LETTER &&
      {1'b0, rsp_item.out_char} < 9'(kscs_pkg::FIRST_LETTER) + 9'(ALPHABET_SIZE))
    else $error("substituted item is not a letter");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.status == kscs_pkg::ST_OK ||
                  rsp_item.status == kscs_pkg::ST_PASS ||
                  rsp_item.status == kscs_pkg::ST_NOT_READY)
    else $error("result item has an unknown status");

endmodule

bind keyword_substitution_cipher_top kscs_checker #(
  .ALPHABET_SIZE(ALPHABET_SIZE)
) u_kscs_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req_item (req_item),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_item (rsp_item)
);
